### hdl/psq_pkg.sv
package psq_pkg;

    localparam int unsigned CAPACITY_DEF       = 16;
    localparam int unsigned VALUE_WIDTH_DEF    = 32;
    localparam int unsigned PRIORITY_WIDTH_DEF = 8;

    // Operation codes on the request channel.
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Error codes reported with every result.
    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_EMPTY = 2'd2
    } psq_err_t;

    // Command broadcast to every cell of the chain at once.
    typedef struct packed {
        logic push;
        logic pop;
    } psq_ctrl_t;

endpackage

### hdl/psq_cell.sv
module psq_cell #(
    parameter int unsigned VALUE_WIDTH    = psq_pkg::VALUE_WIDTH_DEF,
    parameter int unsigned PRIORITY_WIDTH = psq_pkg::PRIORITY_WIDTH_DEF
) (
    input  logic                      aclk,
    input  psq_pkg::psq_ctrl_t        ctrl,
    input  logic                      occupied,
    input  logic [VALUE_WIDTH-1:0]    new_value,
    input  logic [PRIORITY_WIDTH-1:0] new_priority,
    input  logic                      left_beats,
    input  logic [VALUE_WIDTH-1:0]    left_value,
    input  logic [PRIORITY_WIDTH-1:0] left_priority,
    input  logic [VALUE_WIDTH-1:0]    right_value,
    input  logic [PRIORITY_WIDTH-1:0] right_priority,
    output logic                      beats,
    output logic [VALUE_WIDTH-1:0]    value,
    output logic [PRIORITY_WIDTH-1:0] priority_out
);

    logic [VALUE_WIDTH-1:0]    value_reg;
    logic [VALUE_WIDTH-1:0]    value_next;
    logic [PRIORITY_WIDTH-1:0] priority_reg;
    logic [PRIORITY_WIDTH-1:0] priority_next;

    // This cell stays in place on a push when it holds a strictly higher priority.
    assign beats = occupied && (priority_reg > new_priority);

    always_comb begin
        priority if (ctrl.pop) begin
            value_next    = right_value;
            priority_next = right_priority;
        end else if (ctrl.push && !beats) begin
            if (left_beats) begin
                value_next    = new_value;
                priority_next = new_priority;
            end else begin
                value_next    = left_value;
                priority_next = left_priority;
            end
        end else begin
            value_next    = value_reg;
            priority_next = priority_reg;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg    <= value_next;
        priority_reg <= priority_next;
    end

    assign value        = value_reg;
    assign priority_out = priority_reg;

endmodule

### hdl/priority_stack_queue.sv
// A request's result is registered and shows in the cycle after it is accepted.
// Throughput: one push or pop per cycle; every cell of the chain compares and
// shifts in parallel, so the request rate is limited only by the result handshake.
// Reset: synchronous, active low; it empties the queue and drops a pending result.
// Stored entries are not cleared; only slots below the count are ever shown.
module priority_stack_queue #(
    parameter int unsigned CAPACITY       = psq_pkg::CAPACITY_DEF,
    parameter int unsigned VALUE_WIDTH    = psq_pkg::VALUE_WIDTH_DEF,
    parameter int unsigned PRIORITY_WIDTH = psq_pkg::PRIORITY_WIDTH_DEF,
    localparam int unsigned COUNT_WIDTH   = $clog2(CAPACITY + 1)
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_opcode,
    input  logic [VALUE_WIDTH-1:0]    s_item_value,
    input  logic [PRIORITY_WIDTH-1:0] s_item_priority,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [VALUE_WIDTH-1:0]    m_head_value,
    output logic [PRIORITY_WIDTH-1:0] m_head_priority,
    output logic [COUNT_WIDTH-1:0]    m_entry_count,
    output logic                      m_is_empty,
    output logic [1:0]                m_op_error
);

    // The queue is a row of cells, slot 0 being the head. On a push each cell
    // compares its priority with the new one; cells with a strictly higher
    // priority keep their entry, the first cell that does not takes the new
    // entry, and every cell after it takes its left neighbor's entry. A pop
    // moves every entry one cell toward the head. Occupancy of a cell follows
    // from the entry count, so no per-cell valid bit is needed.

    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    psq_pkg::psq_err_t      err_reg;
    psq_pkg::psq_err_t      err_next;

    logic                   accept;
    logic                   is_full;
    logic                   is_empty;
    psq_pkg::psq_ctrl_t     ctrl;

    logic [VALUE_WIDTH-1:0]    cell_value    [CAPACITY];
    logic [PRIORITY_WIDTH-1:0] cell_priority [CAPACITY];
    logic                      cell_beats    [CAPACITY];

    // The result register holds until taken; the state only moves when a new
    // request is accepted, which also frees the result register in that cycle.
    assign s_ready  = !out_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign is_full  = (count_reg == COUNT_WIDTH'(CAPACITY));
    assign is_empty = (count_reg == '0);

    always_comb begin
        ctrl     = '0;
        err_next = err_reg;
        count_next = count_reg;
        if (accept) begin
            err_next = psq_pkg::ERR_NONE;
            unique case (s_opcode)
                psq_pkg::OP_PUSH: begin
                    if (is_full) begin
                        err_next = psq_pkg::ERR_FULL;
                    end else begin
                        ctrl.push  = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                psq_pkg::OP_POP: begin
                    if (is_empty) begin
                        err_next = psq_pkg::ERR_EMPTY;
                    end else begin
                        ctrl.pop   = 1'b1;
                        count_next = count_reg - 1'b1;
                    end
                end
                default: begin
                    err_next = psq_pkg::ERR_NONE;
                end
            endcase
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (accept) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            err_reg       <= psq_pkg::ERR_NONE;
        end else begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            err_reg       <= err_next;
        end
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic                      left_beats;
        logic [VALUE_WIDTH-1:0]    left_value;
        logic [PRIORITY_WIDTH-1:0] left_priority;
        logic [VALUE_WIDTH-1:0]    right_value;
        logic [PRIORITY_WIDTH-1:0] right_priority;

        if (i == 0) begin : g_first
            // The head has nothing ahead of it, so it takes a new entry it does not beat.
            assign left_beats    = 1'b1;
            assign left_value    = s_item_value;
            assign left_priority = s_item_priority;
        end else begin : g_inner
            assign left_beats    = cell_beats[i-1];
            assign left_value    = cell_value[i-1];
            assign left_priority = cell_priority[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_value    = '0;
            assign right_priority = '0;
        end else begin : g_body
            assign right_value    = cell_value[i+1];
            assign right_priority = cell_priority[i+1];
        end

        psq_cell #(
            .VALUE_WIDTH   (VALUE_WIDTH),
            .PRIORITY_WIDTH(PRIORITY_WIDTH)
        ) u_cell (
            .aclk          (aclk),
            .ctrl          (ctrl),
            .occupied      (count_reg > COUNT_WIDTH'(i)),
            .new_value     (s_item_value),
            .new_priority  (s_item_priority),
            .left_beats    (left_beats),
            .left_value    (left_value),
            .left_priority (left_priority),
            .right_value   (right_value),
            .right_priority(right_priority),
            .beats         (cell_beats[i]),
            .value         (cell_value[i]),
            .priority_out  (cell_priority[i])
        );
    end

    // The result is read straight from the head cell, the count and the error
    // register, which hold while the result waits.
    assign m_valid         = out_valid_reg;
    assign m_head_value    = is_empty ? '0 : cell_value[0];
    assign m_head_priority = is_empty ? '0 : cell_priority[0];
    assign m_entry_count   = count_reg;
    assign m_is_empty      = is_empty;
    assign m_op_error      = err_reg;

endmodule

### hdl/psq_checker.sv
module psq_checker #(
    parameter int unsigned CAPACITY       = psq_pkg::CAPACITY_DEF,
    parameter int unsigned VALUE_WIDTH    = psq_pkg::VALUE_WIDTH_DEF,
    parameter int unsigned PRIORITY_WIDTH = psq_pkg::PRIORITY_WIDTH_DEF,
    localparam int unsigned COUNT_WIDTH   = $clog2(CAPACITY + 1)
) (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input logic                      s_opcode,
    input logic [VALUE_WIDTH-1:0]    s_item_value,
    input logic [PRIORITY_WIDTH-1:0] s_item_priority,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic [VALUE_WIDTH-1:0]    m_head_value,
    input logic [PRIORITY_WIDTH-1:0] m_head_priority,
    input logic [COUNT_WIDTH-1:0]    m_entry_count,
    input logic                      m_is_empty,
    input logic [1:0]                m_op_error
);

    // A stalled result holds its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_head_value)
            && $stable(m_entry_count) && $stable(m_op_error))
        else $error("stalled result changed");

    // Every accepted request yields a result in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted request produced no result");

    // An empty queue shows a zero head and a zero count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_empty |-> m_entry_count == '0 && m_head_value == '0
            && m_head_priority == '0)
        else $error("empty queue shows an entry");

    // A dropped push means the queue is full; an ignored pop means it is empty.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_op_error == psq_pkg::ERR_FULL |->
            m_entry_count == COUNT_WIDTH'(CAPACITY))
        else $error("push dropped while not full");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_op_error == psq_pkg::ERR_EMPTY |-> m_is_empty)
        else $error("pop ignored while not empty");

endmodule

bind priority_stack_queue psq_checker #(
    .CAPACITY      (CAPACITY),
    .VALUE_WIDTH   (VALUE_WIDTH),
    .PRIORITY_WIDTH(PRIORITY_WIDTH)
) u_psq_checker (.*);
